[design/spectrum_bin_heatmap_color_defines.svh]
// ============================================================================
// Assertion macros for the spectrum bin heat-map color block
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef SPECTRUM_BIN_HEATMAP_COLOR_DEFINES_SVH
`define SPECTRUM_BIN_HEATMAP_COLOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SBHC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/sbhc_pkg.sv]
// ============================================================================
// Spectrum bin heat-map color package
// Widths, band codes, colormap slopes and the divider stage payload type.
// ============================================================================
`default_nettype none

package sbhc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_SAMPLE_WIDTH  = 24;
   localparam int DEF_FRACTION_BITS = 8;

   // Fixed field widths.
   localparam int FULL_SCALE_WIDTH = 16;
   localparam int FULL_SCALE_INT   = 35;
   localparam int MAG_WIDTH        = 24;
   localparam int COLOR_WIDTH      = 8;
   localparam int NUM_WIDTH        = 28;
   localparam int DEN_WIDTH        = FULL_SCALE_WIDTH + 1;
   localparam int TENTH_WIDTH      = FULL_SCALE_WIDTH + 4;
   localparam int BAND_WIDTH       = 3;

   // Register port.
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FULL_SCALE = '0;

   // Colormap bands.
   localparam logic [BAND_WIDTH-1:0] BAND_BLUE_CYAN    = 3'd0;
   localparam logic [BAND_WIDTH-1:0] BAND_CYAN_GREEN   = 3'd1;
   localparam logic [BAND_WIDTH-1:0] BAND_GREEN_YELLOW = 3'd2;
   localparam logic [BAND_WIDTH-1:0] BAND_YELLOW_RED   = 3'd3;
   localparam logic [BAND_WIDTH-1:0] BAND_RED          = 3'd4;

   localparam logic [COLOR_WIDTH-1:0] COLOR_MAX  = '1;
   localparam logic [COLOR_WIDTH-1:0] COLOR_ZERO = '0;

   // Band edges sit at one, three and six tenths of full scale.
   localparam logic [TENTH_WIDTH-1:0] TENTHS_SCALE = TENTH_WIDTH'(10);
   localparam logic [TENTH_WIDTH-1:0] EDGE_CYAN    = TENTH_WIDTH'(3);
   localparam logic [TENTH_WIDTH-1:0] EDGE_YELLOW  = TENTH_WIDTH'(6);

   // Slopes and offsets, scaled so every band numerator is an integer.
   // 255/0.1, 2*382.5, 255/0.3, 255 and 2*637.5.
   localparam logic [NUM_WIDTH-1:0] SLOPE_BLUE_CYAN     = NUM_WIDTH'(2550);
   localparam logic [NUM_WIDTH-1:0] OFFSET_CYAN_GREEN   = NUM_WIDTH'(765);
   localparam logic [NUM_WIDTH-1:0] SLOPE_GREEN_YELLOW  = NUM_WIDTH'(850);
   localparam logic [NUM_WIDTH-1:0] OFFSET_GREEN_YELLOW = NUM_WIDTH'(255);
   localparam logic [NUM_WIDTH-1:0] SLOPE_YELLOW_RED    = NUM_WIDTH'(1275);

   // Payload handed from one divider cell to the next. The low bits hold
   // the numerator bits still to be shifted in, and take the quotient bits.
   typedef struct packed {
      logic [DEN_WIDTH-1:0]   rem;
      logic [COLOR_WIDTH-1:0] bits;
      logic [DEN_WIDTH-1:0]   den;
      logic [MAG_WIDTH-1:0]   mag;
      logic [BAND_WIDTH-1:0]  band;
   } sbhc_div_type;

endpackage

`default_nettype wire

[design/sbhc_root_cell.sv]
// ============================================================================
// Square root cell
// One digit-by-digit step of the integer square root: brings down two
// radicand bits, tries the next root bit and passes the result onward.
// ============================================================================
`default_nettype none

module sbhc_root_cell #(
   parameter int SAMPLE_WIDTH = sbhc_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_stall,
   input  logic [2*SAMPLE_WIDTH-1:0] up_rad,
   input  logic [SAMPLE_WIDTH+1:0]   up_rem,
   input  logic [SAMPLE_WIDTH-1:0]   up_root,
   output logic                      dn_valid,
   input  logic                      dn_stall,
   output logic [2*SAMPLE_WIDTH-1:0] dn_rad,
   output logic [SAMPLE_WIDTH+1:0]   dn_rem,
   output logic [SAMPLE_WIDTH-1:0]   dn_root
);
   import sbhc_pkg::*;

   localparam int RAD_WIDTH = 2 * SAMPLE_WIDTH;
   localparam int CUR_WIDTH = SAMPLE_WIDTH + 4;

   logic                    valid_ff;
   logic                    valid_in;
   logic [RAD_WIDTH-1:0]    rad_ff;
   logic [RAD_WIDTH-1:0]    rad_in;
   logic [SAMPLE_WIDTH+1:0] rem_ff;
   logic [SAMPLE_WIDTH+1:0] rem_in;
   logic [SAMPLE_WIDTH-1:0] root_ff;
   logic [SAMPLE_WIDTH-1:0] root_in;
   logic [CUR_WIDTH-1:0]    current;
   logic [CUR_WIDTH-1:0]    trial;
   logic [CUR_WIDTH-1:0]    diff;
   logic                    take;
   logic                    load;

   // The cell holds its item while the next cell is full and stalled.
   assign up_stall = valid_ff && dn_stall;
   assign load     = up_valid && !up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // Trial subtraction of 4*root+1 from the remainder with two new bits.
   always_comb begin
      current = {up_rem, up_rad[RAD_WIDTH-1 -: 2]};
      trial   = CUR_WIDTH'({up_root, 2'b01});
      diff    = current - trial;
      take    = (current >= trial);
      rem_in  = take ? diff[SAMPLE_WIDTH+1:0] : current[SAMPLE_WIDTH+1:0];
      root_in = {up_root[SAMPLE_WIDTH-2:0], take};
      rad_in  = {up_rad[RAD_WIDTH-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rad   = rad_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;

endmodule

`default_nettype wire

[design/sbhc_div_cell.sv]
// ============================================================================
// Divider cell
// One restoring division step: shifts in a numerator bit, subtracts the
// denominator when it fits and shifts the quotient bit in at the bottom.
// ============================================================================
`default_nettype none

module sbhc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_stall,
   input  sbhc_pkg::sbhc_div_type up_data,
   output logic                  dn_valid,
   input  logic                  dn_stall,
   output sbhc_pkg::sbhc_div_type dn_data
);
   import sbhc_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   sbhc_div_type         data_ff;
   sbhc_div_type         data_in;
   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   divisor;
   logic [DEN_WIDTH:0]   diff;
   logic                 take;
   logic                 load;

   // The cell holds its item while the next cell is full and stalled.
   assign up_stall = valid_ff && dn_stall;
   assign load     = up_valid && !up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // The partial remainder stays below the denominator between steps.
   always_comb begin
      trial        = {up_data.rem, up_data.bits[COLOR_WIDTH-1]};
      divisor      = {1'b0, up_data.den};
      diff         = trial - divisor;
      take         = (trial >= divisor);
      data_in      = up_data;
      data_in.rem  = take ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
      data_in.bits = {up_data.bits[COLOR_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

[design/sbhc_band.sv]
// ============================================================================
// Colormap band stage
// Places the magnitude in one of the five bands against full scale and sets
// up the numerator and denominator for the channel that changes.
// ============================================================================
`default_nettype none

module sbhc_band #(
   parameter int SAMPLE_WIDTH = sbhc_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [sbhc_pkg::FULL_SCALE_WIDTH-1:0]  full_scale,
   input  logic                                   up_valid,
   output logic                                   up_stall,
   input  logic [SAMPLE_WIDTH-1:0]                up_root,
   output logic                                   dn_valid,
   input  logic                                   dn_stall,
   output sbhc_pkg::sbhc_div_type                 dn_data
);
   import sbhc_pkg::*;

   localparam int CMP_WIDTH =
      (SAMPLE_WIDTH > FULL_SCALE_WIDTH) ? SAMPLE_WIDTH : FULL_SCALE_WIDTH;

   logic                        valid_ff;
   logic                        valid_in;
   sbhc_div_type                data_ff;
   sbhc_div_type                data_in;
   logic                        below_full;
   logic [FULL_SCALE_WIDTH-1:0] m_short;
   logic [TENTH_WIDTH-1:0]      m_tenths;
   logic [TENTH_WIDTH-1:0]      f_one;
   logic [TENTH_WIDTH-1:0]      f_three;
   logic [TENTH_WIDTH-1:0]      f_six;
   logic [NUM_WIDTH-1:0]        m_num;
   logic [NUM_WIDTH-1:0]        f_num;
   logic [NUM_WIDTH-1:0]        num;
   logic [DEN_WIDTH-1:0]        den;
   logic [BAND_WIDTH-1:0]       band;
   logic                        load;

   assign up_stall = valid_ff && dn_stall;
   assign load     = up_valid && !up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // Band select. Below full scale the magnitude fits the register width.
   always_comb begin
      below_full = (CMP_WIDTH'(up_root) < CMP_WIDTH'(full_scale));
      m_short    = FULL_SCALE_WIDTH'(up_root);
      m_tenths   = TENTH_WIDTH'(m_short) * TENTHS_SCALE;
      f_one      = TENTH_WIDTH'(full_scale);
      f_three    = f_one * EDGE_CYAN;
      f_six      = f_one * EDGE_YELLOW;
      if (!below_full) begin
         band = BAND_RED;
      end else if (m_tenths < f_one) begin
         band = BAND_BLUE_CYAN;
      end else if (m_tenths < f_three) begin
         band = BAND_CYAN_GREEN;
      end else if (m_tenths < f_six) begin
         band = BAND_GREEN_YELLOW;
      end else begin
         band = BAND_YELLOW_RED;
      end
   end

   // Numerator and denominator of the changing channel. Every band keeps
   // the quotient within eight bits.
   always_comb begin
      m_num = NUM_WIDTH'(m_short);
      f_num = NUM_WIDTH'(full_scale);
      case (band)
         BAND_BLUE_CYAN: begin
            num = m_num * SLOPE_BLUE_CYAN;
            den = DEN_WIDTH'(full_scale);
         end
         BAND_CYAN_GREEN: begin
            num = f_num * OFFSET_CYAN_GREEN - m_num * SLOPE_BLUE_CYAN;
            den = {full_scale, 1'b0};
         end
         BAND_GREEN_YELLOW: begin
            num = m_num * SLOPE_GREEN_YELLOW - f_num * OFFSET_GREEN_YELLOW;
            den = DEN_WIDTH'(full_scale);
         end
         BAND_YELLOW_RED: begin
            num = (f_num - m_num) * SLOPE_YELLOW_RED;
            den = {full_scale, 1'b0};
         end
         default: begin
            num = '0;
            den = DEN_WIDTH'(1);
         end
      endcase
      data_in.rem  = DEN_WIDTH'(num >> COLOR_WIDTH);
      data_in.bits = num[COLOR_WIDTH-1:0];
      data_in.den  = den;
      data_in.mag  = MAG_WIDTH'(up_root);
      data_in.band = band;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

[design/spectrum_bin_heatmap_color.sv]
// ============================================================================
// Spectrum bin heat-map color
// Magnitude of a complex spectrum bin and its five-band jet-style color.
// ============================================================================
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  real_part, imag_part
//   rsp      out        rsp_valid/rsp_stall  magnitude, red, green, blue
//   csr      in/out     psel/penable/pready  full_scale_amplitude at 0x0
//
// One bin enters per cycle and one result leaves per cycle while rsp_stall
// stays low. Stages in order: squaring, sum, one square root cell per root
// bit, band setup, eight divider cells, output.
// Reset clears all valid flags and loads the full-scale register; no
// clearing pass is needed. A stalled output holds its result and each stage
// stalls only when it and every stage after it are full.
// ============================================================================
`default_nettype none

module spectrum_bin_heatmap_color #(
   parameter int SAMPLE_WIDTH  = sbhc_pkg::DEF_SAMPLE_WIDTH,
   parameter int FRACTION_BITS = sbhc_pkg::DEF_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_imag_part,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sbhc_pkg::MAG_WIDTH-1:0]        rsp_magnitude,
   output logic [sbhc_pkg::COLOR_WIDTH-1:0]      rsp_red,
   output logic [sbhc_pkg::COLOR_WIDTH-1:0]      rsp_green,
   output logic [sbhc_pkg::COLOR_WIDTH-1:0]      rsp_blue,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sbhc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [sbhc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [sbhc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import sbhc_pkg::*;

   localparam int RAD_WIDTH = 2 * SAMPLE_WIDTH;
   localparam logic [FULL_SCALE_WIDTH-1:0] FULL_SCALE_RESET =
      FULL_SCALE_WIDTH'(FULL_SCALE_INT << FRACTION_BITS);

   // Register port.
   logic [FULL_SCALE_WIDTH-1:0] full_scale_ff;
   logic [FULL_SCALE_WIDTH-1:0] full_scale_in;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic                        csr_write;

   // Squaring and sum stages.
   logic                    sq_valid_ff;
   logic                    sq_valid_in;
   logic                    sq_stall;
   logic [SAMPLE_WIDTH-1:0] re_raw;
   logic [SAMPLE_WIDTH-1:0] im_raw;
   logic [SAMPLE_WIDTH-1:0] re_abs;
   logic [SAMPLE_WIDTH-1:0] im_abs;
   logic [RAD_WIDTH-1:0]    re_sq_ff;
   logic [RAD_WIDTH-1:0]    re_sq_in;
   logic [RAD_WIDTH-1:0]    im_sq_ff;
   logic [RAD_WIDTH-1:0]    im_sq_in;
   logic                    sum_valid_ff;
   logic                    sum_valid_in;
   logic                    sum_stall;
   logic [RAD_WIDTH-1:0]    sum_ff;
   logic [RAD_WIDTH-1:0]    sum_in;

   // Square root chain.
   logic                    rt_valid [SAMPLE_WIDTH+1];
   logic                    rt_stall [SAMPLE_WIDTH+1];
   logic [RAD_WIDTH-1:0]    rt_rad   [SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH+1:0] rt_rem   [SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH-1:0] rt_root  [SAMPLE_WIDTH+1];

   // Divider chain.
   logic         dv_valid [COLOR_WIDTH+1];
   logic         dv_stall [COLOR_WIDTH+1];
   sbhc_div_type dv_data  [COLOR_WIDTH+1];

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [MAG_WIDTH-1:0]   rsp_magnitude_ff;
   logic [COLOR_WIDTH-1:0] rsp_red_ff;
   logic [COLOR_WIDTH-1:0] rsp_red_in;
   logic [COLOR_WIDTH-1:0] rsp_green_ff;
   logic [COLOR_WIDTH-1:0] rsp_green_in;
   logic [COLOR_WIDTH-1:0] rsp_blue_ff;
   logic [COLOR_WIDTH-1:0] rsp_blue_in;
   logic [COLOR_WIDTH-1:0] quotient;
   logic                   out_stall;

   // ------------------------------------------------------------------
   // Register port: a write completes in the access phase.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      full_scale_in = full_scale_ff;
      if (csr_write && (csr_index == REG_FULL_SCALE)) begin
         full_scale_in = csr_pwdata[FULL_SCALE_WIDTH-1:0];
      end
      csr_prdata = '0;
      if (csr_index == REG_FULL_SCALE) begin
         csr_prdata = CSR_DATA_WIDTH'(full_scale_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RESET;
      end else begin
         full_scale_ff <= full_scale_in;
      end
   end

   // ------------------------------------------------------------------
   // Absolute values and squares. The most negative sample maps to
   // 2^(SAMPLE_WIDTH-1) exactly as an unsigned value.
   // ------------------------------------------------------------------
   assign sq_stall    = sq_valid_ff && sum_stall;
   assign req_stall   = sq_stall;
   assign sq_valid_in = sq_stall ? sq_valid_ff : req_valid;

   always_comb begin
      re_raw   = req_real_part;
      im_raw   = req_imag_part;
      re_abs   = re_raw[SAMPLE_WIDTH-1] ? (~re_raw) + SAMPLE_WIDTH'(1) : re_raw;
      im_abs   = im_raw[SAMPLE_WIDTH-1] ? (~im_raw) + SAMPLE_WIDTH'(1) : im_raw;
      re_sq_in = re_abs * re_abs;
      im_sq_in = im_abs * im_abs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !sq_stall) begin
         re_sq_ff <= re_sq_in;
         im_sq_ff <= im_sq_in;
      end
   end

   // ------------------------------------------------------------------
   // Sum of squares; it never exceeds 2^(2*SAMPLE_WIDTH-1).
   // ------------------------------------------------------------------
   assign sum_stall    = sum_valid_ff && rt_stall[0];
   assign sum_valid_in = sum_stall ? sum_valid_ff : sq_valid_ff;
   assign sum_in       = re_sq_ff + im_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_valid_ff && !sum_stall) begin
         sum_ff <= sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Square root: one cell per root bit, most significant first.
   // ------------------------------------------------------------------
   assign rt_valid[0] = sum_valid_ff;
   assign rt_rad[0]   = sum_ff;
   assign rt_rem[0]   = '0;
   assign rt_root[0]  = '0;

   for (genvar i = 0; i < SAMPLE_WIDTH; i++) begin : g_root
      if (i < SAMPLE_WIDTH - 1) begin : g_mid
         sbhc_root_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (rt_valid[i]),
            .up_stall (rt_stall[i]),
            .up_rad   (rt_rad[i]),
            .up_rem   (rt_rem[i]),
            .up_root  (rt_root[i]),
            .dn_valid (rt_valid[i+1]),
            .dn_stall (rt_stall[i+1]),
            .dn_rad   (rt_rad[i+1]),
            .dn_rem   (rt_rem[i+1]),
            .dn_root  (rt_root[i+1])
         );
      end else begin : g_last
         sbhc_root_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (rt_valid[i]),
            .up_stall (rt_stall[i]),
            .up_rad   (rt_rad[i]),
            .up_rem   (rt_rem[i]),
            .up_root  (rt_root[i]),
            .dn_valid (rt_valid[i+1]),
            .dn_stall (rt_stall[i+1]),
            .dn_rad   (),
            .dn_rem   (),
            .dn_root  (rt_root[i+1])
         );
      end
   end

   // ------------------------------------------------------------------
   // Band select and divider setup.
   // ------------------------------------------------------------------
   sbhc_band #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_band (
      .clock      (clock),
      .reset      (reset),
      .full_scale (full_scale_ff),
      .up_valid   (rt_valid[SAMPLE_WIDTH]),
      .up_stall   (rt_stall[SAMPLE_WIDTH]),
      .up_root    (rt_root[SAMPLE_WIDTH]),
      .dn_valid   (dv_valid[0]),
      .dn_stall   (dv_stall[0]),
      .dn_data    (dv_data[0])
   );

   // ------------------------------------------------------------------
   // Divider: one cell per quotient bit.
   // ------------------------------------------------------------------
   for (genvar k = 0; k < COLOR_WIDTH; k++) begin : g_div
      sbhc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_valid[k]),
         .up_stall (dv_stall[k]),
         .up_data  (dv_data[k]),
         .dn_valid (dv_valid[k+1]),
         .dn_stall (dv_stall[k+1]),
         .dn_data  (dv_data[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Color assembly and output register.
   // ------------------------------------------------------------------
   assign out_stall              = rsp_valid_ff && rsp_stall;
   assign dv_stall[COLOR_WIDTH]  = out_stall;
   assign rsp_valid_in           = out_stall ? rsp_valid_ff : dv_valid[COLOR_WIDTH];
   assign quotient               = dv_data[COLOR_WIDTH].bits;

   always_comb begin
      case (dv_data[COLOR_WIDTH].band)
         BAND_BLUE_CYAN: begin
            rsp_red_in   = COLOR_ZERO;
            rsp_green_in = quotient;
            rsp_blue_in  = COLOR_MAX;
         end
         BAND_CYAN_GREEN: begin
            rsp_red_in   = COLOR_ZERO;
            rsp_green_in = COLOR_MAX;
            rsp_blue_in  = quotient;
         end
         BAND_GREEN_YELLOW: begin
            rsp_red_in   = quotient;
            rsp_green_in = COLOR_MAX;
            rsp_blue_in  = COLOR_ZERO;
         end
         BAND_YELLOW_RED: begin
            rsp_red_in   = COLOR_MAX;
            rsp_green_in = quotient;
            rsp_blue_in  = COLOR_ZERO;
         end
         default: begin
            rsp_red_in   = COLOR_MAX;
            rsp_green_in = COLOR_ZERO;
            rsp_blue_in  = COLOR_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_valid[COLOR_WIDTH] && !out_stall) begin
         rsp_magnitude_ff <= dv_data[COLOR_WIDTH].mag;
         rsp_red_ff       <= rsp_red_in;
         rsp_green_ff     <= rsp_green_in;
         rsp_blue_ff      <= rsp_blue_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;

endmodule

`default_nettype wire

[design/sbhc_checker.sv]
// ============================================================================
// Spectrum bin heat-map color port checker
// Watches the result channel of the top level for holding and color rules.
// ============================================================================
`default_nettype none

`include "spectrum_bin_heatmap_color_defines.svh"

module sbhc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [sbhc_pkg::MAG_WIDTH-1:0]   rsp_magnitude,
   input logic [sbhc_pkg::COLOR_WIDTH-1:0] rsp_red,
   input logic [sbhc_pkg::COLOR_WIDTH-1:0] rsp_green,
   input logic [sbhc_pkg::COLOR_WIDTH-1:0] rsp_blue
);
   import sbhc_pkg::*;

   // A stalled result stays offered and unchanged.
   `SBHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_magnitude) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "result changed while stalled")

   // Every band drives one channel to full intensity.
   `SBHC_ASSERT_IMPLY(a_one_full, clock, reset, rsp_valid, rsp_red == COLOR_MAX || rsp_green == COLOR_MAX || rsp_blue == COLOR_MAX, "no channel at full intensity")

   // Red and blue never light together in a jet colormap.
   `SBHC_ASSERT_IMPLY(a_red_blue, clock, reset, rsp_valid, rsp_red == COLOR_ZERO || rsp_blue == COLOR_ZERO, "red and blue both lit")

   // Reset leaves no result on the output.
   `SBHC_ASSERT_IMPLY(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid, "result offered right after reset")

endmodule

bind spectrum_bin_heatmap_color sbhc_checker u_sbhc_checker (.*);

`default_nettype wire
